### rtl/core/kpc_pkg.sv
// Shared types and constants for the matrix keypad press classifier.
// No dependencies; imported by every module in rtl/core.
package kpc_pkg;

    localparam int PINS      = 8;
    localparam int LINE_W    = 3;
    localparam int CNT_W     = 8;
    localparam int IDX_W     = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;
    localparam int LANE_SEL_W = 3;

    // column order is reversed inside each nibble
    localparam int COL_SWAP = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
    localparam logic [CNT_W-1:0] CNT_ONE = 8'h01;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KBD_COUNT = 1'b1;

    localparam logic [CNT_W-1:0] THRESHOLD_RST = 8'd100;
    localparam logic [1:0]       KBD_COUNT_RST = 2'd0;

    typedef struct packed {
        logic             kbd;
        logic [IDX_W-1:0] idx;
        logic             is_long;
    } t_evt;

    typedef struct packed {
        logic hit;
        t_evt evt;
    } t_lane_evt;

    typedef struct packed {
        logic [PINS-1:0] pend;
        logic            take;
    } t_merge_stat;

endpackage

### rtl/core/matrix_keypad_press_classifier.sv
// Matrix keypad press classifier, top level.
// Depends on kpc_pkg, kpc_lane and kpc_merge.
//
// Usage:
// - s_axis: one beat per scanned line (line index and eight pin bits).
//   Lines at or above NUM_LINES are dropped without effect.
// - m_axis: one beat per press event; tuser set for a long press, clear for a
//   short press on release; tlast marks the final event of a line.
// - cfg: register writes (0 threshold, 1 keyboard count), always ready; write
//   only while no events are pending.
// Eight column lanes update their counters in the cycle a line is accepted;
// the events wait in the pending register and the first one moves on to the
// m_axis output register, from which it leaves. Events leave one per cycle
// while m_axis is ready; the next line is taken in the cycle the last event
// of the current one moves to the output register. When m_axis stalls, the
// output register holds its beat and s_axis_tready drops once the pending
// events cannot drain.
// Reset clears all press counters and loads threshold 100, keyboard count 0 (no split).
module matrix_keypad_press_classifier #(
    parameter int NUM_LINES         = 6,
    parameter int NUM_KEYS          = 48,
    parameter int KEYS_PER_KEYBOARD = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [2:0] line_index, [10:3] pin_bits, rest zero
    input  logic [kpc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] keyboard_number, [6:1] button_number, [7] zero
    output logic [kpc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] long_press
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [kpc_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import kpc_pkg::*;

    logic [CNT_W-1:0]  r_threshold;
    logic [1:0]        r_kbd_count;
    logic [LINE_W-1:0] w_line;
    logic [PINS-1:0]   w_pins;
    logic              w_s_acc;
    logic              w_line_ok;
    logic              w_en;
    logic              w_split;
    t_lane_evt         w_lane [PINS];
    t_evt              w_oevt;
    t_merge_stat       w_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_kbd_count <= KBD_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_KBD_COUNT: r_kbd_count <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign w_line    = s_axis_tdata[LINE_W-1:0];
    assign w_pins    = s_axis_tdata[LINE_W +: PINS];
    assign w_s_acc   = s_axis_tvalid && s_axis_tready;
    assign w_line_ok = (32'(w_line) < NUM_LINES);
    assign w_en      = w_s_acc && w_line_ok;
    assign w_split   = (r_kbd_count > 2'd1);

    genvar g;
    generate
        for (g = 0; g < PINS; g++) begin : g_lane
            kpc_lane #(
                .LANE              (g),
                .NUM_LINES         (NUM_LINES),
                .NUM_KEYS          (NUM_KEYS),
                .KEYS_PER_KEYBOARD (KEYS_PER_KEYBOARD)
            ) u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (w_en),
                .i_line      (w_line),
                .i_pressed   (w_pins[g]),
                .i_threshold (r_threshold),
                .i_split     (w_split),
                .o_evt       (w_lane[g])
            );
        end
    endgenerate

    kpc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_s_acc),
        .i_lane      (w_lane),
        .i_out_ready (m_axis_tready),
        .o_load_ok   (s_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_evt       (w_oevt),
        .o_last      (m_axis_tlast),
        .o_stat      (w_stat)
    );

    assign m_axis_tdata = {1'b0, w_oevt.idx, w_oevt.kbd};
    assign m_axis_tuser = w_oevt.is_long;

    a_bad_line_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && !w_line_ok) |=> (w_stat.pend == '0))
        else $error("dropped line left events pending");

    a_more_after_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |-> (w_stat.pend != '0))
        else $error("event without tlast but nothing pending");

    a_hold_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_stat.pend) > 1) |-> !s_axis_tready)
        else $error("line accepted while several events pending");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_split) |-> (32'(w_oevt.idx) < NUM_KEYS))
        else $error("button number out of range");

endmodule

### rtl/core/kpc_lane.sv
// One column lane: press counters for every line of one column, event detect.
// Depends on kpc_pkg.
module kpc_lane #(
    parameter int LANE              = 0,
    parameter int NUM_LINES         = 6,
    parameter int NUM_KEYS          = 48,
    parameter int KEYS_PER_KEYBOARD = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [kpc_pkg::LINE_W-1:0]    i_line,
    input  logic                          i_pressed,
    input  logic [kpc_pkg::CNT_W-1:0]     i_threshold,
    input  logic                          i_split,
    output kpc_pkg::t_lane_evt            o_evt
);
    import kpc_pkg::*;

    localparam int SEL_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int COL   = LANE ^ COL_SWAP;

    logic [CNT_W-1:0]     r_cnt [NUM_LINES];
    logic [CNT_W-1:0]     n_cnt;
    logic [NUM_LINES-1:0] w_btn_ok;
    logic [NUM_LINES-1:0] w_kbd_tab;
    logic [IDX_W-1:0]     w_idx_tab [NUM_LINES];
    logic [IDX_W-1:0]     w_btn_tab [NUM_LINES];
    logic [SEL_W-1:0]     w_sel;
    logic [CNT_W-1:0]     w_cur;
    logic [CNT_W-1:0]     w_inc;
    logic                 w_hit;
    logic                 w_long;

    genvar ln;
    generate
        for (ln = 0; ln < NUM_LINES; ln++) begin : g_tab
            localparam int BTN = COL * NUM_LINES + ln;
            localparam int KBD = BTN / KEYS_PER_KEYBOARD;
            localparam int IDX = BTN % KEYS_PER_KEYBOARD;
            assign w_btn_ok[ln]  = (BTN < NUM_KEYS);
            assign w_kbd_tab[ln] = 1'(KBD);
            assign w_idx_tab[ln] = IDX_W'(IDX);
            assign w_btn_tab[ln] = IDX_W'(BTN);
        end
    endgenerate

    assign w_sel = i_line[SEL_W-1:0];
    assign w_cur = r_cnt[w_sel];
    assign w_inc = w_cur + CNT_ONE;

    always_comb begin
        n_cnt  = w_cur;
        w_hit  = 1'b0;
        w_long = 1'b0;
        if (w_btn_ok[w_sel]) begin
            if (i_pressed) begin
                if (w_cur != CNT_MAX) begin
                    if (w_inc > i_threshold) begin
                        w_hit  = 1'b1;
                        w_long = 1'b1;
                        n_cnt  = CNT_MAX;
                    end else begin
                        n_cnt = w_inc;
                    end
                end
            end else if (w_cur != '0) begin
                // release after a reported long press stays silent
                w_hit = (w_cur != CNT_MAX);
                n_cnt = '0;
            end
        end
    end

    assign o_evt.hit         = i_en & w_hit;
    assign o_evt.evt.kbd     = i_split ? w_kbd_tab[w_sel] : 1'b0;
    assign o_evt.evt.idx     = i_split ? w_idx_tab[w_sel] : w_btn_tab[w_sel];
    assign o_evt.evt.is_long = w_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LINES; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (i_en && w_btn_ok[w_sel]) begin
            r_cnt[w_sel] <= n_cnt;
        end
    end

endmodule

### rtl/core/kpc_merge.sv
// Merge stage: holds the lane events of one line and sends them one per beat,
// lowest lane first, through a registered output. Depends on kpc_pkg.
module kpc_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  kpc_pkg::t_lane_evt    i_lane [kpc_pkg::PINS],
    input  logic                  i_out_ready,
    output logic                  o_load_ok,
    output logic                  o_valid,
    output kpc_pkg::t_evt         o_evt,
    output logic                  o_last,
    output kpc_pkg::t_merge_stat  o_stat
);
    import kpc_pkg::*;

    logic [PINS-1:0]       r_pend;
    logic [PINS-1:0]       n_pend;
    t_evt                  r_evt [PINS];
    logic                  r_ovalid;
    t_evt                  r_oevt;
    logic                  r_olast;
    logic [LANE_SEL_W-1:0] w_sel;
    logic [PINS-1:0]       w_low;
    logic [PINS-1:0]       w_rest;
    logic [PINS-1:0]       w_hits;
    logic                  w_pull;
    logic                  w_take;

    always_comb begin
        w_sel = '0;
        for (int i = PINS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                w_sel = LANE_SEL_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PINS; i++) begin
            w_hits[i] = i_lane[i].hit;
        end
    end

    assign w_low     = r_pend & (~r_pend + PINS'(1));
    assign w_rest    = r_pend & ~w_low;
    assign w_pull    = !r_ovalid || i_out_ready;
    assign w_take    = w_pull && (r_pend != '0);
    assign o_load_ok = (r_pend == '0) || (w_take && (w_rest == '0));

    always_comb begin
        n_pend = r_pend;
        if (i_load) begin
            n_pend = w_hits;
        end else if (w_take) begin
            n_pend = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_take) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_oevt  <= r_evt[w_sel];
            r_olast <= (w_rest == '0);
        end
        if (i_load) begin
            for (int i = 0; i < PINS; i++) begin
                r_evt[i] <= i_lane[i].evt;
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_evt       = r_oevt;
    assign o_last      = r_olast;
    assign o_stat.pend = r_pend;
    assign o_stat.take = w_take;

endmodule
